[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every enabled clock edge.
`define RLSE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property in the form antecedent implies consequent in the same cycle.
`define RLSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/rlse_pkg.sv]
// ----------------------------------------------------------------------------
// Run-length string expander package
// Operation codes, queue entry type and character constants shared by the
// front end, the back end and the checker.
// ----------------------------------------------------------------------------
package rlse_pkg;

	// Action codes as they arrive on the input channel.
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_NEXT  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Character codes.
	localparam logic [7:0] CHR_SPACE   = 8'd32;
	localparam logic [7:0] CHR_ZERO    = 8'd48;
	localparam logic [7:0] CHR_NINE    = 8'd57;
	localparam logic [7:0] CHR_UPPER_A = 8'd65;
	localparam logic [7:0] CHR_UPPER_Z = 8'd90;
	localparam logic [7:0] CHR_LOWER_A = 8'd97;
	localparam logic [7:0] CHR_LOWER_Z = 8'd122;

	// Classified operation handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_LETTER = 3'd0,
		OP_DIGIT  = 3'd1,
		OP_NEXT   = 3'd2,
		OP_QUERY  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_kind_t;

	// Queue entry: the kind plus a letter code or a digit value.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
	} rlse_op_t;

endpackage

[sv/rlse_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/rlse_front.sv]
// ----------------------------------------------------------------------------
// Run-length string expander front end
// Accepts input transactions, classifies each into an operation, drops stray
// bytes and queues the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rlse_front
	import rlse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,
	output logic       op_valid,
	output rlse_op_t   op,
	input  logic       op_ready
);

	localparam int QDEPTH = 2;

	rlse_op_t   queue_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	rlse_op_t   cls_op;
	logic       cls_keep;
	logic       is_letter;
	logic       is_digit;
	logic       push;
	logic       pop;

	// Character classes of the incoming byte.
	assign is_letter = ((s_axis_tdata >= CHR_UPPER_A) && (s_axis_tdata <= CHR_UPPER_Z)) ||
		((s_axis_tdata >= CHR_LOWER_A) && (s_axis_tdata <= CHR_LOWER_Z));
	assign is_digit  = (s_axis_tdata >= CHR_ZERO) && (s_axis_tdata <= CHR_NINE);

	// Classify the transaction; stray bytes are not queued at all.
	always_comb begin
		cls_op   = '{kind: OP_LETTER, data: s_axis_tdata};
		cls_keep = 1'b1;
		unique case (s_axis_tuser)
			ACT_LOAD: begin
				if (is_letter) begin
					cls_op.kind = OP_LETTER;
				end else if (is_digit) begin
					cls_op.kind = OP_DIGIT;
					cls_op.data = s_axis_tdata - CHR_ZERO;
				end else begin
					cls_keep = 1'b0;
				end
			end
			ACT_NEXT:  cls_op.kind = OP_NEXT;
			ACT_QUERY: cls_op.kind = OP_QUERY;
			ACT_CLEAR: cls_op.kind = OP_CLEAR;
			default:   cls_keep = 1'b0;
		endcase
	end

	assign s_axis_tready = (fill_q != 2'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready && cls_keep;
	assign op_valid      = (fill_q != 2'd0);
	assign op            = queue_q[rd_ptr_q];
	assign pop           = op_valid && op_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls_op;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

[sv/rlse_back.sv]
// ----------------------------------------------------------------------------
// Run-length string expander back end
// Builds pairs from letters and digits, stores closed pairs in the pair table
// and serves next and query requests through an output register.
// ----------------------------------------------------------------------------
module rlse_back
	import rlse_pkg::*;
#(
	parameter int MAX_PAIRS  = 64,
	parameter int COUNT_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	input  rlse_op_t   op,
	output logic       op_ready,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,
	output logic [1:0] m_axis_tuser
);

	localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int SW = $clog2(MAX_PAIRS + 1);
	localparam int CW = COUNT_BITS;
	localparam int EW = COUNT_BITS + 4;
	localparam int TW = 8 + COUNT_BITS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} back_state_t;

	back_state_t   state_q;
	logic [SW-1:0] total_q;
	logic [SW-1:0] slot_q;
	logic [7:0]    open_letter_q;
	logic [CW-1:0] open_count_q;
	logic          open_valid_q;
	logic          ovf_q;
	logic          is_next_q;
	logic          out_valid_q;
	logic [7:0]    out_letter_q;
	logic          out_more_q;
	logic          out_ovf_q;

	logic          take;
	logic          close_keep;
	logic          tbl_full;
	logic          close_wr;
	logic [EW-1:0] scaled;
	logic [CW-1:0] digit_count;
	logic [TW-1:0] rd_data;
	logic [7:0]    head_letter;
	logic [CW-1:0] head_count;
	logic [CW-1:0] dec_count;
	logic          hit;
	logic          out_free;
	logic          exec_go;
	logic          exec_wb;
	logic [SW-1:0] next_slot;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [TW-1:0] ram_wr_data;

	// Queue handshake: operations are taken only in the idle state.
	assign op_ready = (state_q == ST_IDLE);
	assign take     = op_valid && op_ready;

	// Closing the open pair stores it only if its count is nonzero.
	assign close_keep = open_valid_q && (open_count_q != '0);
	assign tbl_full   = (total_q == SW'(MAX_PAIRS));
	assign close_wr   = take && (op.kind != OP_DIGIT) && (op.kind != OP_CLEAR) &&
		close_keep && !tbl_full;

	// Decimal accumulate with saturation: count*10 + digit.
	assign scaled = EW'({open_count_q, 3'b000}) + EW'({open_count_q, 1'b0}) +
		EW'(op.data[3:0]);
	assign digit_count = (|scaled[EW-1:CW]) ? {CW{1'b1}} : scaled[CW-1:0];

	// Head pair read from the table.
	assign head_letter = rd_data[TW-1:CW];
	assign head_count  = rd_data[CW-1:0];
	assign dec_count   = head_count - CW'(1);
	assign hit         = (slot_q < total_q);
	assign out_free    = !out_valid_q || m_axis_tready;
	assign exec_go     = (state_q == ST_EXEC) && out_free;
	assign exec_wb     = exec_go && is_next_q && hit;
	assign next_slot   = (exec_wb && (dec_count == '0)) ? slot_q + SW'(1) : slot_q;

	// Table write port: appends while closing, write-back while serving.
	always_comb begin
		ram_wr_en   = close_wr || exec_wb;
		ram_wr_addr = total_q[AW-1:0];
		ram_wr_data = {open_letter_q, open_count_q};
		if (exec_wb) begin
			ram_wr_addr = slot_q[AW-1:0];
			ram_wr_data = {head_letter, dec_count};
		end
	end

	rlse_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_PAIRS)
	) u_tbl (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (state_q == ST_READ),
		.rd_addr (slot_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Control state, pair building and request sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			total_q       <= '0;
			slot_q        <= '0;
			open_letter_q <= '0;
			open_count_q  <= '0;
			open_valid_q  <= 1'b0;
			ovf_q         <= 1'b0;
			is_next_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (op.kind)
							OP_LETTER, OP_NEXT, OP_QUERY: begin
								if (close_keep && tbl_full) begin
									ovf_q <= 1'b1;
								end
								if (close_wr) begin
									total_q <= total_q + SW'(1);
								end
								if (op.kind == OP_LETTER) begin
									open_letter_q <= op.data;
									open_count_q  <= '0;
									open_valid_q  <= 1'b1;
								end else begin
									open_valid_q <= 1'b0;
									is_next_q    <= (op.kind == OP_NEXT);
									state_q      <= ST_READ;
								end
							end
							OP_DIGIT: begin
								if (open_valid_q) begin
									open_count_q <= digit_count;
								end
							end
							OP_CLEAR: begin
								total_q       <= '0;
								slot_q        <= '0;
								open_letter_q <= '0;
								open_count_q  <= '0;
								open_valid_q  <= 1'b0;
								ovf_q         <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						slot_q  <= next_slot;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_letter_q <= hit ? head_letter : CHR_SPACE;
			out_more_q   <= (next_slot < total_q);
			out_ovf_q    <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_letter_q;
	assign m_axis_tuser  = {out_ovf_q, out_more_q};

endmodule

[sv/run_length_string_expander.sv]
// ----------------------------------------------------------------------------
// Run-length string expander
// Takes a run-length compressed string byte by byte and hands out the
// expanded letters one at a time on request.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata (low bit up)   tuser (low bit up)
// s_axis   in   byte_value[7:0]      action[1:0]
// m_axis   out  letter[7:0]          has_more, overflowed
//
// A load or clear transaction is handled in the idle state; a next or query
// request steps through idle, read and exec (close the open pair, table read,
// update and result); read covers the registered read of the single pair table.
// A two-entry queue sits between the input channel and the back end, so input
// transactions keep being accepted while a result waits in the output register.
// Stray bytes are dropped at the input without using a queue entry.
// Reset is asynchronous; the pair table needs no clearing pass.
//
module run_length_string_expander
	import rlse_pkg::*;
#(
	parameter int MAX_PAIRS  = 64,
	parameter int COUNT_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // byte_value[7:0]
	input  logic [1:0] s_axis_tuser,   // action[1:0]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // letter[7:0]
	output logic [1:0] m_axis_tuser    // [0] has_more, [1] overflowed
);

	logic     op_valid;
	logic     op_ready;
	rlse_op_t op;

	// Front end: accept, classify and queue.
	rlse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.op_valid      (op_valid),
		.op            (op),
		.op_ready      (op_ready)
	);

	// Back end: pair table and request handling.
	rlse_back #(
		.MAX_PAIRS  (MAX_PAIRS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (op_valid),
		.op            (op),
		.op_ready      (op_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

[sv/rlse_checker.sv]
// ----------------------------------------------------------------------------
// Run-length string expander checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlse_checker
	import rlse_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);

	logic is_alpha;

	assign is_alpha = ((m_axis_tdata >= CHR_UPPER_A) && (m_axis_tdata <= CHR_UPPER_Z)) ||
		((m_axis_tdata >= CHR_LOWER_A) && (m_axis_tdata <= CHR_LOWER_Z));

	// A stalled result keeps its payload until taken.
	`RLSE_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// Only stored letters or the space come out.
	`RLSE_ASSERT_IMPL(a_out_letter, clk, arst_n, m_axis_tvalid, is_alpha || (m_axis_tdata == CHR_SPACE), "result is neither a letter nor a space")

	// A space means the table is exhausted, so nothing can remain.
	`RLSE_ASSERT_IMPL(a_space_empty, clk, arst_n, m_axis_tvalid && (m_axis_tdata == CHR_SPACE), !m_axis_tuser[0], "space returned while letters remain")

endmodule

bind run_length_string_expander rlse_checker u_rlse_checker (.*);
